@@ rtl/pcaw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcaw_pkg
// Shared widths, register indexes, reset values and payload types for the
// PID controller with clamped-integrator anti-windup.
// ----------------------------------------------------------------------------
package pcaw_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int GAIN_W       = 16;
	localparam int STEP_W       = 16;
	localparam int LIMIT_W      = 16;
	localparam int INTEG_W      = 48;
	localparam int ERR_W        = SAMPLE_WIDTH + 1;
	localparam int DIFF_W       = SAMPLE_WIDTH + 2;
	// time step carries 16 fraction bits
	localparam int FRAC_W       = 16;
	localparam int DIV_N        = ERR_W + FRAC_W;
	// integral term shift and final Q8.8 shift
	localparam int I_SHIFT      = 16;
	localparam int OUT_SHIFT    = 8;
	// wide enough for gain x saturated 48-bit value plus the other terms
	localparam int ACC_W        = 66;

	localparam int CFG_IDX_W    = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HI = 3'd4;

	localparam logic [GAIN_W-1:0]  KP_RST = 16'h0100;
	localparam logic [GAIN_W-1:0]  KI_RST = 16'h0000;
	localparam logic [GAIN_W-1:0]  KD_RST = 16'h0000;
	localparam logic [LIMIT_W-1:0] LO_RST = 16'h8000;
	localparam logic [LIMIT_W-1:0] HI_RST = 16'h7FFF;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic                           command;
		logic signed [SAMPLE_WIDTH-1:0] target_value;
		logic signed [SAMPLE_WIDTH-1:0] measured_value;
		logic        [STEP_W-1:0]       time_step;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] drive_value;
		logic                           clamped;
	} rsp_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [LIMIT_W-1:0] lo;
		logic [LIMIT_W-1:0] hi;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/pcaw_addsub.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcaw_addsub
// Shared wide adder/subtractor used by the error, difference, divide,
// product and sum steps of the controller sequence.
// ----------------------------------------------------------------------------
module pcaw_addsub (
	input  wire logic [pcaw_pkg::ACC_W-1:0] a,
	input  wire logic [pcaw_pkg::ACC_W-1:0] b,
	input  wire logic                       sub,
	output logic      [pcaw_pkg::ACC_W-1:0] sum
);

	localparam int AW = pcaw_pkg::ACC_W;

	assign sum = a + (b ^ {AW{sub}}) + AW'(sub);

endmodule
`default_nettype wire

@@ rtl/pcaw_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcaw_core
// Sequencer and datapath registers: error, serial restoring divide for the
// derivative and shift-add products for the integral step and the three
// gains through one shared adder, then the anti-windup decision and clamp.
// ----------------------------------------------------------------------------
module pcaw_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pcaw_pkg::req_t req,
	input  wire pcaw_pkg::cfg_t cfg,
	input  wire logic           take,
	output logic                idle,
	output logic                done,
	output pcaw_pkg::rsp_t      result
);

	localparam int W       = pcaw_pkg::SAMPLE_WIDTH;
	localparam int AW      = pcaw_pkg::ACC_W;
	localparam int EW      = pcaw_pkg::ERR_W;
	localparam int DW      = pcaw_pkg::DIFF_W;
	localparam int IW      = pcaw_pkg::INTEG_W;
	localparam int GW      = pcaw_pkg::GAIN_W;
	localparam int SW      = pcaw_pkg::STEP_W;
	localparam int LW      = pcaw_pkg::LIMIT_W;
	localparam int FW      = pcaw_pkg::FRAC_W;
	localparam int DN      = pcaw_pkg::DIV_N;
	localparam int ISH     = pcaw_pkg::I_SHIFT;
	localparam int OSH     = pcaw_pkg::OUT_SHIFT;
	localparam int CNT_MAX = (DN > GW) ? DN : GW;
	localparam int CNT_W   = $clog2(CNT_MAX);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_DIFF, ST_ABS, ST_DIV, ST_NEG,
		ST_MUL, ST_SUM, ST_DECIDE, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_DT, PH_KP, PH_KD, PH_KI, PH_KI2
	} phase_t;

	function automatic logic [AW-1:0] sx_smp(input logic [W-1:0] v);
		return {{(AW-W){v[W-1]}}, v};
	endfunction

	function automatic logic [AW-1:0] sx_err(input logic [EW-1:0] v);
		return {{(AW-EW){v[EW-1]}}, v};
	endfunction

	function automatic logic [AW-1:0] sx_int(input logic [IW-1:0] v);
		return {{(AW-IW){v[IW-1]}}, v};
	endfunction

	function automatic logic [AW-1:0] sx_lim(input logic [LW-1:0] v);
		return {{(AW-LW){v[LW-1]}}, v};
	endfunction

	// saturate to the signed 48-bit range
	function automatic logic [IW-1:0] sat_int(input logic [AW-1:0] v);
		logic [AW-IW:0] top;
		top = v[AW-1:IW-1];
		if ((&top) || !(|top))
			return v[IW-1:0];
		else if (v[AW-1])
			return {1'b1, {(IW-1){1'b0}}};
		else
			return {1'b0, {(IW-1){1'b1}}};
	endfunction

	state_t             state_q;
	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IW-1:0]      integ_q;
	logic [EW-1:0]      last_err_q;
	logic               last_vld_q;

	logic [W-1:0]       tgt_q;
	logic [W-1:0]       meas_q;
	logic [SW-1:0]      dt_q;
	logic [EW-1:0]      err_q;
	logic               neg_q;
	logic [AW-1:0]      acc_q;
	logic [AW-1:0]      mcand_q;
	logic [GW-1:0]      mplier_q;
	logic [DN-1:0]      qn_q;
	logic [IW-1:0]      deriv_q;
	logic [IW-1:0]      tent_q;
	logic [AW-1:0]      pd_q;
	logic [AW-1:0]      val_q;
	logic [W-1:0]       drive_q;
	logic               clamped_q;

	logic [AW-1:0]      add_a;
	logic [AW-1:0]      add_b;
	logic               add_sub;
	logic [AW-1:0]      add_sum;
	logic [FW:0]        rem_sh;
	logic               div_ge;
	logic               mul_last;
	logic               div_last;
	logic               go_div;
	logic [AW-1:0]      lo_ext;
	logic [AW-1:0]      hi_ext;
	logic               above;
	logic               below;
	logic               err_neg;
	logic               err_pos;
	logic               keep;

	pcaw_addsub u_addsub (
		.a   (add_a),
		.b   (add_b),
		.sub (add_sub),
		.sum (add_sum)
	);

	assign rem_sh   = {acc_q[FW-1:0], qn_q[DN-1]};
	assign div_ge   = ~add_sum[AW-1];
	assign mul_last = (cnt_q == CNT_W'(GW - 1));
	assign div_last = (cnt_q == CNT_W'(DN - 1));
	assign go_div   = last_vld_q && (dt_q != '0);
	assign lo_ext   = sx_lim(cfg.lo);
	assign hi_ext   = sx_lim(cfg.hi);
	assign above    = $signed(val_q) > $signed(hi_ext);
	assign below    = $signed(val_q) < $signed(lo_ext);
	assign err_neg  = err_q[EW-1];
	assign err_pos  = !err_q[EW-1] && (err_q != '0);
	assign keep     = above ? err_neg : (below ? err_pos : 1'b1);

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_ERR: begin
				add_a   = sx_smp(tgt_q);
				add_b   = sx_smp(meas_q);
				add_sub = 1'b1;
			end
			ST_DIFF: begin
				add_a   = sx_err(err_q);
				add_b   = sx_err(last_err_q);
				add_sub = 1'b1;
			end
			ST_ABS: begin
				add_b   = acc_q;
				add_sub = neg_q;
			end
			ST_DIV: begin
				add_a   = {{(AW-FW-1){1'b0}}, rem_sh};
				add_b   = {{(AW-SW){1'b0}}, dt_q};
				add_sub = 1'b1;
			end
			ST_NEG: begin
				add_b   = {{(AW-DN){1'b0}}, qn_q};
				add_sub = neg_q;
			end
			ST_MUL: begin
				// the gain's sign bit carries negative weight
				add_a   = acc_q;
				add_b   = mplier_q[0] ? mcand_q : '0;
				add_sub = (phase_q != PH_DT) && mul_last;
			end
			ST_SUM: begin
				add_a = {{ISH{acc_q[AW-1]}}, acc_q[AW-1:ISH]};
				add_b = pd_q;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	// sequencer, architectural state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_DT;
			cnt_q      <= '0;
			integ_q    <= '0;
			last_err_q <= '0;
			last_vld_q <= 1'b0;
			drive_q    <= '0;
			clamped_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						drive_q   <= '0;
						clamped_q <= 1'b0;
						if (req.command == pcaw_pkg::CMD_CLEAR) begin
							integ_q    <= '0;
							last_err_q <= '0;
							last_vld_q <= 1'b0;
							state_q    <= ST_DONE;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_ERR: begin
					cnt_q <= '0;
					if (go_div) begin
						state_q <= ST_DIFF;
					end else begin
						phase_q <= PH_DT;
						state_q <= ST_MUL;
					end
				end
				ST_DIFF: state_q <= ST_ABS;
				ST_ABS: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last)
						state_q <= ST_NEG;
				end
				ST_NEG: begin
					cnt_q   <= '0;
					phase_q <= PH_DT;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_last) begin
						cnt_q <= '0;
						case (phase_q)
							PH_DT:   phase_q <= PH_KP;
							PH_KP:   phase_q <= PH_KD;
							PH_KD:   phase_q <= PH_KI;
							default: state_q <= ST_SUM;
						endcase
					end
				end
				ST_SUM: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (phase_q == PH_KI && !keep) begin
						// integral held: redo the integral term with the old sum
						phase_q <= PH_KI2;
						state_q <= ST_MUL;
					end else begin
						if (phase_q == PH_KI)
							integ_q <= tent_q;
						if (below) begin
							drive_q   <= lo_ext[W-1:0];
							clamped_q <= 1'b1;
						end else if (above) begin
							drive_q   <= hi_ext[W-1:0];
							clamped_q <= 1'b1;
						end else begin
							drive_q   <= val_q[W-1:0];
							clamped_q <= 1'b0;
						end
						last_err_q <= err_q;
						last_vld_q <= 1'b1;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					tgt_q  <= req.target_value;
					meas_q <= req.measured_value;
					dt_q   <= req.time_step;
				end
			end
			ST_ERR: begin
				err_q <= add_sum[EW-1:0];
				if (!go_div) begin
					deriv_q  <= '0;
					acc_q    <= sx_int(integ_q);
					mcand_q  <= sx_err(add_sum[EW-1:0]);
					mplier_q <= dt_q;
				end
			end
			ST_DIFF: begin
				acc_q <= add_sum;
				neg_q <= add_sum[DW-1];
			end
			ST_ABS: begin
				qn_q  <= {add_sum[EW-1:0], {FW{1'b0}}};
				acc_q <= '0;
			end
			ST_DIV: begin
				acc_q <= div_ge ? add_sum : {{(AW-FW-1){1'b0}}, rem_sh};
				qn_q  <= {qn_q[DN-2:0], div_ge};
			end
			ST_NEG: begin
				deriv_q  <= sat_int(add_sum);
				acc_q    <= sx_int(integ_q);
				mcand_q  <= sx_err(err_q);
				mplier_q <= dt_q;
			end
			ST_MUL: begin
				acc_q    <= add_sum;
				mcand_q  <= {mcand_q[AW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[GW-1:1]};
				if (mul_last) begin
					case (phase_q)
						PH_DT: begin
							tent_q   <= sat_int(add_sum);
							acc_q    <= '0;
							mcand_q  <= sx_err(err_q);
							mplier_q <= cfg.kp;
						end
						PH_KP: begin
							mcand_q  <= sx_int(deriv_q);
							mplier_q <= cfg.kd;
						end
						PH_KD: begin
							pd_q     <= add_sum;
							acc_q    <= '0;
							mcand_q  <= sx_int(tent_q);
							mplier_q <= cfg.ki;
						end
						default: acc_q <= add_sum;
					endcase
				end
			end
			ST_SUM: val_q <= {{OSH{add_sum[AW-1]}}, add_sum[AW-1:OSH]};
			ST_DECIDE: begin
				if (phase_q == PH_KI && !keep) begin
					acc_q    <= '0;
					mcand_q  <= sx_int(integ_q);
					mplier_q <= cfg.ki;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle               = (state_q == ST_IDLE);
	assign done               = (state_q == ST_DONE);
	assign result.drive_value = drive_q;
	assign result.clamped     = clamped_q;

endmodule
`default_nettype wire

@@ rtl/pid_controller_anti_windup_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_unit
// PID controller with clamped-integrator anti-windup, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one beat per update: command, target and measured
//   samples, time step. rsp channel returns one beat per request: the
//   clamped drive value and a clamp flag. cfg channel writes the gains and
//   output limits by index; it is always ready and should only be used
//   while no request is in flight.
//   An update passes from acceptance to the result beat through one error
//   step, four 16-step shift-add products on the shared adder, a 33-step
//   restoring divide when a derivative is formed, and a fifth product when
//   anti-windup holds the integral. A clear command goes straight to the
//   result. The arithmetic steps share one adder, so one request is worked
//   on at a time and req_ready is low meanwhile.
//   The result waits in an output register; the next request is accepted
//   while it waits. If the receiver stalls with a result still held, the
//   following result is held in the core until the register frees.
//   Reset clears the integral, previous error and the limits/gains to
//   their defaults.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire pcaw_pkg::req_t                       req_data,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output pcaw_pkg::rsp_t                            rsp_data,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [pcaw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pcaw_pkg::GAIN_W-1:0]          cfg_data
);

	pcaw_pkg::cfg_t cfg_q;
	pcaw_pkg::rsp_t rsp_q;
	pcaw_pkg::rsp_t core_result;
	logic           rsp_valid_q;
	logic           core_idle;
	logic           core_done;
	logic           slot_free;
	logic           core_take;
	logic           core_start;

	assign cfg_ready  = 1'b1;
	assign req_ready  = core_idle;
	assign core_start = req_valid && core_idle;
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign core_take  = core_done && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp <= pcaw_pkg::KP_RST;
			cfg_q.ki <= pcaw_pkg::KI_RST;
			cfg_q.kd <= pcaw_pkg::KD_RST;
			cfg_q.lo <= pcaw_pkg::LO_RST;
			cfg_q.hi <= pcaw_pkg::HI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pcaw_pkg::REG_KP: cfg_q.kp <= cfg_data;
				pcaw_pkg::REG_KI: cfg_q.ki <= cfg_data;
				pcaw_pkg::REG_KD: cfg_q.kd <= cfg_data;
				pcaw_pkg::REG_LO: cfg_q.lo <= cfg_data;
				pcaw_pkg::REG_HI: cfg_q.hi <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcaw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.req    (req_data),
		.cfg    (cfg_q),
		.take   (core_take),
		.idle   (core_idle),
		.done   (core_done),
		.result (core_result)
	);

	// output register: load a finished beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (core_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take)
			rsp_q <= core_result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PID controller with clamped-integrator
// anti-windup. Requests are driven with random gaps, the response side
// stalls at random and once for a long stretch, and every result beat is
// checked against a cycle-free fixed-point model of the controller held
// here.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int     DRAIN_CYCLES = 130;
	localparam int     HOLD_CYCLES  = 600;
	localparam longint INTEG_MAX    = (longint'(1) <<< (pcaw_pkg::INTEG_W - 1)) - 1;
	localparam longint INTEG_MIN    = -INTEG_MAX - 1;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_ready;
	pcaw_pkg::req_t                 req_data  = '0;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	pcaw_pkg::rsp_t                 rsp_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pcaw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcaw_pkg::GAIN_W-1:0]    cfg_data  = '0;

	// controller model: settings and state
	longint gain_p   = 256;
	longint gain_i   = 0;
	longint gain_d   = 0;
	longint limit_lo = -32768;
	longint limit_hi = 32767;
	longint integ_acc   = 0;
	longint prev_err    = 0;
	bit     prev_err_ok = 1'b0;

	pcaw_pkg::rsp_t drive_queue[$];
	int   fail_count    = 0;
	bit   idle_enable   = 1'b1;
	int   hold_requests = 0;
	int   holds_served  = 0;
	int   hold_left     = 0;

	pid_controller_anti_windup_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint clip48(input longint v);
		if (v > INTEG_MAX)
			return INTEG_MAX;
		if (v < INTEG_MIN)
			return INTEG_MIN;
		return v;
	endfunction

	// drive level in whole units, floored
	function automatic longint drive_level(input longint err, input longint integ,
			input longint rate);
		longint acc;
		acc = gain_p * err + ((gain_i * integ) >>> pcaw_pkg::I_SHIFT) + gain_d * rate;
		return acc >>> pcaw_pkg::OUT_SHIFT;
	endfunction

	function automatic pcaw_pkg::rsp_t compute_drive(input pcaw_pkg::req_t item);
		longint         err;
		longint         dt;
		longint         rate;
		longint         tent;
		longint         level;
		pcaw_pkg::rsp_t res;
		res = '0;
		if (item.command == pcaw_pkg::CMD_CLEAR) begin
			integ_acc   = 0;
			prev_err    = 0;
			prev_err_ok = 1'b0;
			return res;
		end
		err  = longint'($signed(item.target_value))
			- longint'($signed(item.measured_value));
		dt   = longint'(item.time_step);
		rate = 0;
		if (prev_err_ok && dt != 0)
			rate = clip48(((err - prev_err) * 65536) / dt);
		tent  = clip48(integ_acc + err * dt);
		level = drive_level(err, tent, rate);
		// take the new integral unless it winds further into saturation
		if (level > limit_hi) begin
			if (err < 0)
				integ_acc = tent;
		end else if (level < limit_lo) begin
			if (err > 0)
				integ_acc = tent;
		end else begin
			integ_acc = tent;
		end
		level = drive_level(err, integ_acc, rate);
		if (level < limit_lo) begin
			res.drive_value = limit_lo[pcaw_pkg::SAMPLE_WIDTH-1:0];
			res.clamped     = 1'b1;
		end else if (level > limit_hi) begin
			res.drive_value = limit_hi[pcaw_pkg::SAMPLE_WIDTH-1:0];
			res.clamped     = 1'b1;
		end else begin
			res.drive_value = level[pcaw_pkg::SAMPLE_WIDTH-1:0];
		end
		prev_err    = err;
		prev_err_ok = 1'b1;
		return res;
	endfunction

	function automatic pcaw_pkg::req_t make_req(input logic cmd, input int target,
			input int measured, input int dt);
		pcaw_pkg::req_t r;
		r.command        = cmd;
		r.target_value   = pcaw_pkg::SAMPLE_WIDTH'(target);
		r.measured_value = pcaw_pkg::SAMPLE_WIDTH'(measured);
		r.time_step      = pcaw_pkg::STEP_W'(dt);
		return r;
	endfunction

	function automatic pcaw_pkg::req_t random_request();
		int base;
		int dt;
		base = int'($urandom_range(4000)) - 2000;
		case ($urandom_range(9))
			0:             dt = 0;
			1:             dt = 65535;
			2, 3, 4, 5:    dt = $urandom_range(1, 2000);
			default:       dt = $urandom_range(65535);
		endcase
		// half the requests use small errors so the integral can build up inside the limits
		if ($urandom_range(1))
			return make_req(($urandom_range(99) < 3) ? pcaw_pkg::CMD_CLEAR
				: pcaw_pkg::CMD_UPDATE, $urandom, $urandom, dt);
		return make_req(($urandom_range(99) < 3) ? pcaw_pkg::CMD_CLEAR
			: pcaw_pkg::CMD_UPDATE, base, base + int'($urandom_range(1000)) - 500, dt);
	endfunction

	function automatic int random_gain();
		case ($urandom_range(3))
			0:       return int'($urandom_range(65535)) - 32768;
			1:       return int'($urandom_range(1200)) - 600;
			2:       return $urandom_range(512);
			default: return 256;
		endcase
	endfunction

	task automatic check_result(input pcaw_pkg::rsp_t got);
		pcaw_pkg::rsp_t want;
		if (drive_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] result beat with no request outstanding: %s %0d %0b",
					$time, "drive/clamped", got.drive_value, got.clamped);
			return;
		end
		want = drive_queue.pop_front();
		if (got.drive_value !== want.drive_value || got.clamped !== want.clamped) begin
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
					$time, want.drive_value, got.drive_value, want.clamped, got.clamped);
		end
	endtask

	// response side: check each beat, stall at random or for a requested hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_result(rsp_data);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= !(idle_enable && $urandom_range(99) < 18);
			end
		end
	end

	// valid is left high on return so back-to-back beats need no second assignment
	task automatic send_request(input pcaw_pkg::req_t item);
		while (idle_enable && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		drive_queue.push_back(compute_drive(item));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_register(input logic [pcaw_pkg::CFG_IDX_W-1:0] idx,
			input int value);
		logic signed [pcaw_pkg::GAIN_W-1:0] word;
		word = pcaw_pkg::GAIN_W'(value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			pcaw_pkg::REG_KP: gain_p   = word;
			pcaw_pkg::REG_KI: gain_i   = word;
			pcaw_pkg::REG_KD: gain_d   = word;
			pcaw_pkg::REG_LO: limit_lo = word;
			pcaw_pkg::REG_HI: limit_hi = word;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int kp, input int ki, input int kd, input int lo,
			input int hi);
		wait_drained();
		write_register(pcaw_pkg::REG_KP, kp);
		write_register(pcaw_pkg::REG_KI, ki);
		write_register(pcaw_pkg::REG_KD, kd);
		write_register(pcaw_pkg::REG_LO, lo);
		write_register(pcaw_pkg::REG_HI, hi);
		// indexes past the last register must be ignored
		write_register(pcaw_pkg::CFG_IDX_W'(pcaw_pkg::REG_HI + 1 + $urandom_range(2)),
			$urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_settings();
		send_request(make_req(pcaw_pkg::CMD_CLEAR, -1, -1, 65535));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 32767, -32768, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, -32768, 32767, 65535));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 0, 0, 1));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 21845, -21846, 43690));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, -21846, 21845, 21845));
		send_request(make_req(pcaw_pkg::CMD_CLEAR, 0, 0, 0));
	endtask

	task automatic test_zero_step();
		apply_settings(256, 128, 64, -32768, 32767);
		send_request(make_req(pcaw_pkg::CMD_CLEAR, 0, 0, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 100, 0, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 200, 0, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 300, 0, 1000));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 300, 0, 0));
	endtask

	task automatic test_anti_windup();
		// build a large positive integral, then narrow the limits around it
		apply_settings(256, 256, 0, -32768, 32767);
		send_request(make_req(pcaw_pkg::CMD_CLEAR, 0, 0, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 1000, 0, 65535));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 1000, 0, 65535));
		apply_settings(256, 256, 0, -500, 500);
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 900, 1000, 4096));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 1100, 1000, 4096));
		// same again on the low side
		apply_settings(0, 256, 0, -32768, 32767);
		send_request(make_req(pcaw_pkg::CMD_CLEAR, 0, 0, 0));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, -1000, 0, 65535));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, -1000, 0, 65535));
		apply_settings(0, 256, 0, -500, 500);
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 1100, 1000, 4096));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 900, 1000, 4096));
	endtask

	task automatic test_crossed_limits();
		apply_settings(256, 0, 0, 100, -100);
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 0, 0, 10));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, 500, 0, 10));
		send_request(make_req(pcaw_pkg::CMD_UPDATE, -500, 0, 10));
	endtask

	task automatic test_back_pressure();
		apply_settings(256, 64, 32, -1024, 1024);
		hold_requests++;
		for (int n = 0; n < 12; n++)
			send_request(random_request());
	endtask

	task automatic test_random_phases();
		int lo;
		int hi;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0) begin
				apply_settings(-32768, 32767, -32768, -32768, 32767);
			end else if (phase == 1) begin
				apply_settings(32767, -32768, 32767, 32767, -32768);
			end else begin
				case ($urandom_range(3))
					0: begin
						lo = -32768;
						hi = 32767;
					end
					1: begin
						lo = int'($urandom_range(65535)) - 32768;
						hi = int'($urandom_range(65535)) - 32768;
						if (lo > hi)
							{lo, hi} = {hi, lo};
					end
					2: begin
						lo = -int'($urandom_range(1, 2000));
						hi = $urandom_range(1, 2000);
					end
					default: begin
						lo = int'($urandom_range(65535)) - 32768;
						hi = int'($urandom_range(65535)) - 32768;
					end
				endcase
				apply_settings(random_gain(), random_gain(), random_gain(), lo, hi);
			end
			// one phase runs flat out on both sides
			idle_enable = (phase != 4);
			for (int n = 0; n < 172; n++)
				send_request(random_request());
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_settings();
		test_zero_step();
		test_anti_windup();
		test_crossed_limits();
		test_back_pressure();
		test_random_phases();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && drive_queue.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#6ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ pid_controller_anti_windup_unit.f @@
rtl/pcaw_pkg.sv
rtl/pcaw_addsub.sv
rtl/pcaw_core.sv
rtl/pid_controller_anti_windup_unit.sv
tb/sv/tb_top.sv
